// File: rtl/icon_scale_alpha_blitter_unit_assert.svh
// Assertion macros shared by the blitter's checker.
// Relies on signals named clock and reset in the scope where a macro is used.
`ifndef ICON_SCALE_ALPHA_BLITTER_UNIT_ASSERT_SVH
`define ICON_SCALE_ALPHA_BLITTER_UNIT_ASSERT_SVH

// Implication checked outside reset
`define ISABU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("isabu implication check failed");

// Next-cycle implication, also checked during reset
`define ISABU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("isabu next-cycle check failed");

`endif

// File: rtl/isabu_pkg.sv
// Shared types, constants and helpers of the icon scale/alpha blitter.
// No dependencies.
`default_nettype none

package isabu_pkg;

   localparam int unsigned ICON_DIM_DEFAULT = 20;
   localparam int unsigned QUEUE_DEPTH      = 4;
   localparam int unsigned CSR_IDX_W        = 3;
   localparam int unsigned CSR_DATA_W       = 24;

   localparam logic [7:0]  COV_ALPHA_STEP   = 8'd85;
   localparam logic [7:0]  BLEND_MAX        = 8'd255;
   localparam logic [7:0]  ALPHA_OPAQUE     = 8'hff;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ICON_SIZE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_STRIDE = 3'd6;

   localparam logic [23:0] FG_COLOR_RESET  = 24'hffffff;
   localparam logic [9:0]  ICON_SIZE_RESET = 10'd20;

   typedef struct packed {
      logic        operation;
      logic [6:0]  byte_index;
      logic [7:0]  byte_value;
      logic [9:0]  col_offset;
      logic [9:0]  row_offset;
      logic [31:0] background;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [23:0] dest_offset;
      logic [31:0] pixel_out;
   } rsp_type;

   typedef struct packed {
      logic [23:0]        fg_color;
      logic [9:0]         icon_size;
      logic signed [12:0] origin_x;
      logic signed [12:0] origin_y;
      logic [12:0]        surface_width;
      logic [12:0]        surface_height;
      logic [12:0]        surface_stride;
   } cfg_type;

   // what the back end does with a queued request
   typedef enum logic [1:0] {
      KIND_DROP  = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_SHADE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  byte_index;
      logic [7:0]  byte_value;
      logic [9:0]  col;
      logic [9:0]  row;
      logic [12:0] px;
      logic [12:0] py;
      logic [23:0] bg;
   } item_type;

   // x / 255 for x <= 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// File: rtl/isabu_front.sv
// Front end: classifies a request into load, shade or drop and clips it.
// Depends on isabu_pkg.
`default_nettype none

module isabu_front
   import isabu_pkg::*;
#(
   parameter int unsigned IconDim = ICON_DIM_DEFAULT
) (
   input  cfg_type  cfg,
   input  req_type  req,
   output item_type item
);

   localparam int unsigned StoreBytes = (IconDim * IconDim + 3) / 4;

   logic signed [13:0] px_s;
   logic signed [13:0] py_s;
   logic               in_square;
   logic               on_surface;
   logic               index_ok;

   // surface position of the pixel
   assign px_s = 14'(cfg.origin_x) + $signed({4'b0, req.col_offset});
   assign py_s = 14'(cfg.origin_y) + $signed({4'b0, req.row_offset});

   assign in_square  = (cfg.icon_size != '0) && (req.col_offset < cfg.icon_size)
                       && (req.row_offset < cfg.icon_size);
   assign on_surface = !px_s[13] && !py_s[13] && (px_s[12:0] < cfg.surface_width)
                       && (py_s[12:0] < cfg.surface_height);
   assign index_ok   = 32'(req.byte_index) < StoreBytes;

   // classify
   always_comb begin
      item.byte_index = req.byte_index;
      item.byte_value = req.byte_value;
      item.col        = req.col_offset;
      item.row        = req.row_offset;
      item.px         = px_s[12:0];
      item.py         = py_s[12:0];
      item.bg         = req.background[23:0];
      if (!req.operation) begin
         item.kind = index_ok ? KIND_LOAD : KIND_DROP;
      end else begin
         item.kind = (in_square && on_surface) ? KIND_SHADE : KIND_DROP;
      end
   end

endmodule

`default_nettype wire

// File: rtl/isabu_fifo.sv
// Short request queue between the front and back ends.
// Depends on isabu_pkg.
`default_nettype none

module isabu_fifo
   import isabu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     full,
   output logic     empty
);

   localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]       count_ff,  count_in;

   assign full     = count_ff == (PtrW+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/isabu_back.sv
// Back end: pipelined nearest-neighbor divide, icon store, blend, output register.
// Depends on isabu_pkg.
`default_nettype none

module isabu_back
   import isabu_pkg::*;
#(
   parameter int unsigned IconDim = ICON_DIM_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_empty,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   localparam int unsigned QW         = $clog2(IconDim);
   localparam int unsigned NW         = 10 + $clog2(IconDim + 1);
   localparam int unsigned XW         = NW + QW;
   localparam int unsigned PixW       = $clog2(IconDim * IconDim);
   localparam int unsigned StoreBytes = (IconDim * IconDim + 3) / 4;
   localparam int unsigned AW         = $clog2(StoreBytes);

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  byte_index;
      logic [7:0]  byte_value;
      logic [NW-1:0] rem_c;
      logic [NW-1:0] rem_r;
      logic [QW-1:0] q_c;
      logic [QW-1:0] q_r;
      logic [12:0] px;
      logic [12:0] py;
      logic [23:0] bg;
   } div_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  sel;
      logic [12:0] px;
      logic [23:0] bg;
   } fetch_type;

   typedef struct packed {
      logic        write;
      logic [23:0] dest;
      logic [15:0] sum_r;
      logic [15:0] sum_g;
      logic [15:0] sum_b;
   } mix_type;

   logic        adv;
   div_type     div_ff  [QW+1];
   logic        dv_ff   [QW+1];
   fetch_type   fet_ff;
   logic        fv_ff;
   logic [7:0]  rd_ff;
   logic [25:0] prod_ff;
   mix_type     mix_ff;
   logic        mv_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rv_ff;

   logic [7:0]  icon_mem [StoreBytes];

   // whole pipeline moves when the output register can take a result
   assign adv       = !rv_ff || rsp_ready;
   assign q_pop     = adv && !q_empty;
   assign rsp_valid = rv_ff;
   assign rsp_payload = rsp_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) dv_ff[k] <= 1'b0;
         fv_ff <= 1'b0;
         mv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= q_pop;
         for (int k = 1; k <= QW; k++) dv_ff[k] <= dv_ff[k-1];
         fv_ff <= dv_ff[QW];
         mv_ff <= fv_ff;
         rv_ff <= mv_ff;
      end
   end

   // divide stage 0: numerators offset * IconDim
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0].kind       <= q_item.kind;
         div_ff[0].byte_index <= q_item.byte_index;
         div_ff[0].byte_value <= q_item.byte_value;
         div_ff[0].rem_c      <= NW'(32'(q_item.col) * IconDim);
         div_ff[0].rem_r      <= NW'(32'(q_item.row) * IconDim);
         div_ff[0].q_c        <= '0;
         div_ff[0].q_r        <= '0;
         div_ff[0].px         <= q_item.px;
         div_ff[0].py         <= q_item.py;
         div_ff[0].bg         <= q_item.bg;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int unsigned Bit = QW - 1 - k;
      logic [XW-1:0] dsh;
      div_type       nxt;

      assign dsh = XW'(cfg.icon_size) << Bit;

      always_comb begin
         nxt = div_ff[k];
         if (XW'(div_ff[k].rem_c) >= dsh) begin
            nxt.rem_c    = NW'(XW'(div_ff[k].rem_c) - dsh);
            nxt.q_c[Bit] = 1'b1;
         end
         if (XW'(div_ff[k].rem_r) >= dsh) begin
            nxt.rem_r    = NW'(XW'(div_ff[k].rem_r) - dsh);
            nxt.q_r[Bit] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= nxt;
         end
      end
   end

   // icon fetch, byte loads and row address product
   logic [PixW-1:0] pix;
   assign pix = PixW'(32'(div_ff[QW].q_r) * IconDim + 32'(div_ff[QW].q_c));

   always_ff @(posedge clock) begin
      if (adv) begin
         if (dv_ff[QW] && div_ff[QW].kind == KIND_LOAD) begin
            icon_mem[AW'(div_ff[QW].byte_index)] <= div_ff[QW].byte_value;
         end
         rd_ff        <= icon_mem[AW'(pix >> 2)];
         fet_ff.kind  <= div_ff[QW].kind;
         fet_ff.sel   <= pix[1:0];
         fet_ff.px    <= div_ff[QW].px;
         fet_ff.bg    <= div_ff[QW].bg;
         prod_ff      <= 26'(div_ff[QW].py) * 26'(cfg.surface_stride);
      end
   end

   // coverage to alpha, channel products
   logic [1:0]  cov;
   logic [7:0]  alpha;
   logic [7:0]  ialpha;
   mix_type     mix_in;

   always_comb begin
      cov    = 2'(rd_ff >> {fet_ff.sel, 1'b0});
      alpha  = 8'(cov) * COV_ALPHA_STEP;
      ialpha = BLEND_MAX - alpha;
      mix_in.write = fet_ff.kind == KIND_SHADE && cov != '0;
      mix_in.dest  = 24'(prod_ff + 26'(fet_ff.px));
      mix_in.sum_r = 16'(cfg.fg_color[23:16]) * 16'(alpha)
                   + 16'(fet_ff.bg[23:16]) * 16'(ialpha);
      mix_in.sum_g = 16'(cfg.fg_color[15:8]) * 16'(alpha)
                   + 16'(fet_ff.bg[15:8]) * 16'(ialpha);
      mix_in.sum_b = 16'(cfg.fg_color[7:0]) * 16'(alpha)
                   + 16'(fet_ff.bg[7:0]) * 16'(ialpha);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mix_ff <= mix_in;
      end
   end

   // divide by 255 and pack the response
   always_comb begin
      rsp_in = '0;
      if (mix_ff.write) begin
         rsp_in.write_enable = 1'b1;
         rsp_in.dest_offset  = mix_ff.dest;
         rsp_in.pixel_out    = {ALPHA_OPAQUE, div255(mix_ff.sum_r),
                                div255(mix_ff.sum_g), div255(mix_ff.sum_b)};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/icon_scale_alpha_blitter_unit.sv
// A request passes the queue, the numerator register, the one-bit-per-stage divider,
// the icon store read, the channel product register and the output register.
// Throughput: one request per cycle; the whole back pipeline stalls with the output register.
// Reset: configuration returns to its reset values and the pipeline empties;
// the icon store keeps its contents and is undefined until loaded.
// Top level: config registers, front classifier, request queue, back pipeline.
// Depends on isabu_pkg, isabu_front, isabu_fifo, isabu_back.
`default_nettype none

module icon_scale_alpha_blitter_unit
   import isabu_pkg::*;
#(
   parameter int unsigned ICON_DIM = ICON_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   item_type front_item;
   item_type q_item;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg_color       <= FG_COLOR_RESET;
         cfg_ff.icon_size      <= ICON_SIZE_RESET;
         cfg_ff.origin_x       <= '0;
         cfg_ff.origin_y       <= '0;
         cfg_ff.surface_width  <= '0;
         cfg_ff.surface_height <= '0;
         cfg_ff.surface_stride <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FG_COLOR:       cfg_ff.fg_color       <= csr_wdata;
            CSR_ICON_SIZE:      cfg_ff.icon_size      <= csr_wdata[9:0];
            CSR_ORIGIN_X:       cfg_ff.origin_x       <= csr_wdata[12:0];
            CSR_ORIGIN_Y:       cfg_ff.origin_y       <= csr_wdata[12:0];
            CSR_SURFACE_WIDTH:  cfg_ff.surface_width  <= csr_wdata[12:0];
            CSR_SURFACE_HEIGHT: cfg_ff.surface_height <= csr_wdata[12:0];
            CSR_SURFACE_STRIDE: cfg_ff.surface_stride <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !q_full;

   isabu_front #(.IconDim(ICON_DIM)) u_front (
      .cfg  (cfg_ff),
      .req  (req_payload),
      .item (front_item)
   );

   isabu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   isabu_back #(.IconDim(ICON_DIM)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: rtl/isabu_checker.sv
// Port-level checker for the blitter, bound to the top level.
// Depends on isabu_pkg and icon_scale_alpha_blitter_unit_assert.svh.
`default_nettype none
`include "icon_scale_alpha_blitter_unit_assert.svh"

module isabu_checker
   import isabu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // a stalled response holds
   `ISABU_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && !rsp_ready, reset || (rsp_valid && $stable(rsp_payload)))

   // a response without a write carries zeros
   `ISABU_ASSERT_IMP(a_nowrite_zero, rsp_valid && !rsp_payload.write_enable, rsp_payload.dest_offset == '0 && rsp_payload.pixel_out == '0)

   // written pixels are opaque
   `ISABU_ASSERT_IMP(a_write_opaque, rsp_valid && rsp_payload.write_enable, rsp_payload.pixel_out[31:24] == ALPHA_OPAQUE)

   // reset empties the output
   `ISABU_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid)

endmodule

bind icon_scale_alpha_blitter_unit isabu_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
